>>> src/scba_pkg.sv
// scba_pkg: types, constants and codes for the size-class block allocator
// no dependencies; imported by the interfaces and the core in src

package scba_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int FREE_DEPTH  = 64;
  localparam int OFFSET_BITS = 40;

  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int SLOT_W   = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(FREE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_CLASSES * FREE_DEPTH;
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  localparam int BLK_W   = 17;
  localparam int POOL_W  = 40;
  localparam int SIZE_W  = 32;
  localparam int SEG_W   = 2 * BLK_W;        // segment bytes and remainders
  localparam int HEAD_W  = OFFSET_BITS + 1;
  localparam int ALN_W   = CLS_W + BLK_W;    // class size in bytes
  localparam int DVD_W   = SEG_W;            // divider dividend width
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BYTES    = 2'd0,
    REG_SEGMENT_BLOCKS = 2'd1,
    REG_POOL_BYTES     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_FREE_REJ  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    DIV_ALLOC,
    DIV_FREE,
    DIV_FILE
  } div_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSEG,
    S_DIV,
    S_CLS,
    S_MALN,
    S_CHK,
    S_SCAN,
    S_CLAIM,
    S_RDW,
    S_MULG,
    S_FILE,
    S_FCHK,
    S_GRANT,
    S_DONE
  } state_t;

  // free-list store port controls
  typedef struct packed {
    logic                we;
    logic                re;
    logic [STORE_AW-1:0] addr;
  } store_ctl_t;

endpackage

>>> src/scba_in_if.sv
// scba_in_if: request channel (valid/ready plus command, size and offset)
// depends on scba_pkg

interface scba_in_if;
  import scba_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [SIZE_W-1:0]      size_bytes;
  logic [OFFSET_BITS-1:0] free_offset;

  modport source (output valid, command, size_bytes, free_offset, input ready);
  modport sink   (input valid, command, size_bytes, free_offset, output ready);
endinterface

>>> src/scba_out_if.sv
// scba_out_if: result channel (valid/ready plus status, offset, granted bytes)
// depends on scba_pkg

interface scba_out_if;
  import scba_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [OFFSET_BITS-1:0] offset;
  logic [SIZE_W-1:0]      granted_bytes;

  modport source (output valid, status, offset, granted_bytes, input ready);
  modport sink   (input valid, status, offset, granted_bytes, output ready);
endinterface

>>> src/size_class_block_allocator_core.sv
// size_class_block_allocator_core: top level, sequencer with a shared divider,
// multiplier and per-class segment state; depends on scba_pkg, scba_in_if,
// scba_out_if and scba_ram

// One request is handled at a time; in_ch.ready is high only while idle. A free
// or an allocate runs a bit-serial divide by block_bytes in 34 shift steps. A
// segment claim that files the old remainder runs another divide. A bad size
// is answered after the divide, or after the aligned-size check when the
// rounded size exceeds the segment. A zero block size is answered without a
// divide. The result sits in an output register, so the next request may be
// taken while it waits. No clearing pass after reset: free lists are only read
// below their fill counts.
module size_class_block_allocator_core
  import scba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  scba_in_if.sink              in_ch,
  scba_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [BLK_W-1:0]  block_r;
  logic [BLK_W-1:0]  segblk_r;
  logic [POOL_W-1:0] pool_r;

  logic [CNT_W-1:0]       cnt_r    [NUM_CLASSES];
  logic [OFFSET_BITS-1:0] segoff_r [NUM_CLASSES];
  logic [SEG_W-1:0]       segrem_r [NUM_CLASSES];
  logic [HEAD_W-1:0]      head_r;

  // request
  logic [SIZE_W-1:0]      size_r;
  logic [OFFSET_BITS-1:0] foff_r;

  logic [SEG_W-1:0] segb_r;
  logic [CLS_W-1:0] cls_r;
  logic [CLS_W-1:0] i_r;
  logic [ALN_W-1:0] aln_r;
  logic [OFFSET_BITS-1:0] fileoff_r;

  // divider
  div_mode_t         dmode_r;
  logic [DVD_W-1:0]  quo_r;
  logic [BLK_W:0]    rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [BLK_W:0]    trial;
  logic              tbit;

  // result
  logic [1:0]             res_status_r;
  logic [OFFSET_BITS-1:0] res_off_r;
  logic [SIZE_W-1:0]      res_grant_r;
  logic                   ovalid_r;
  logic [1:0]             ostatus_r;
  logic [OFFSET_BITS-1:0] ooff_r;
  logic [SIZE_W-1:0]      ogrant_r;

  // shared multiplier
  logic [BLK_W-1:0] mul_a;
  logic [SEG_W-1:0] prod;

  logic [CLS_W-1:0]        idx;
  logic [CNT_W-1:0]        cnt_sel;
  logic [OFFSET_BITS-1:0]  segoff_sel;
  logic [SEG_W-1:0]        segrem_sel;
  logic [OFFSET_BITS-1:0]  ram_rdata;
  logic [OFFSET_BITS-1:0]  ram_wdata;
  store_ctl_t              sctl;

  logic accept;
  logic rem_nz;
  logic q_small;
  logic alloc_bad;
  logic rem_short;
  logic [HEAD_W-1:0] head_sum;
  logic claim_open;
  logic claim_fit;
  logic file_ok;
  logic free_ok;
  logic last_cls;
  logic div_done;
  logic out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !ovalid_r || out_ch.ready;

  assign trial  = {rem_r[BLK_W-1:0], quo_r[DVD_W-1]};
  assign tbit   = (trial >= {1'b0, block_r});
  assign div_done = (dcnt_r == '0);

  assign rem_nz  = (rem_r != '0);
  assign q_small = (quo_r < DVD_W'(NUM_CLASSES));
  // class after rounding up must stay below the class count
  assign alloc_bad = (size_r == '0) || !q_small ||
                     ((quo_r == DVD_W'(NUM_CLASSES - 1)) && rem_nz);

  always_comb begin
    unique case (state_r)
      S_CLAIM:        idx = cls_r;
      S_FILE, S_FCHK: idx = quo_r[CLS_W-1:0];
      default:        idx = i_r;
    endcase
  end

  assign cnt_sel    = cnt_r[idx];
  assign segoff_sel = segoff_r[idx];
  assign segrem_sel = segrem_r[idx];

  assign rem_short  = (segrem_sel < SEG_W'(aln_r));
  assign head_sum   = head_r + HEAD_W'(segb_r);
  assign claim_open = (head_r < HEAD_W'(pool_r));
  assign claim_fit  = (head_sum <= HEAD_W'(pool_r));
  assign last_cls   = (i_r == CLS_W'(NUM_CLASSES - 1));
  assign file_ok = !rem_nz && (quo_r != '0) && q_small &&
                   (cnt_sel < CNT_W'(FREE_DEPTH));
  assign free_ok = (size_r != '0) && file_ok;

  always_comb begin
    unique case (state_r)
      S_MSEG:  mul_a = segblk_r;
      S_MALN:  mul_a = BLK_W'(cls_r);
      default: mul_a = BLK_W'(i_r);
    endcase
  end
  assign prod = mul_a * block_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (block_r == '0) state_nxt = S_DONE;
          else if (in_ch.command == CMD_FREE) state_nxt = S_DIV;
          else state_nxt = S_MSEG;
        end
      end
      S_MSEG: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          unique case (dmode_r)
            DIV_ALLOC: state_nxt = S_CLS;
            DIV_FREE:  state_nxt = S_FCHK;
            default:   state_nxt = S_FILE;
          endcase
        end
      end
      S_CLS:  state_nxt = alloc_bad ? S_DONE : S_MALN;
      S_MALN: state_nxt = S_CHK;
      S_CHK:  state_nxt = (SEG_W'(aln_r) > segb_r) ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (!rem_short) state_nxt = S_GRANT;
        else if (cnt_sel != '0) state_nxt = S_RDW;
        else state_nxt = S_CLAIM;
      end
      S_CLAIM: begin
        if (claim_open && claim_fit) begin
          state_nxt = (segrem_sel != '0) ? S_DIV : S_SCAN;
        end else begin
          state_nxt = last_cls ? S_DONE : S_SCAN;
        end
      end
      S_RDW:   state_nxt = S_MULG;
      S_MULG:  state_nxt = S_DONE;
      S_FILE:  state_nxt = S_SCAN;
      S_FCHK:  state_nxt = S_DONE;
      S_GRANT: state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // store port controls
  always_comb begin
    sctl      = '0;
    ram_wdata = fileoff_r;
    unique case (state_r)
      S_SCAN: begin
        sctl.re   = rem_short && (cnt_sel != '0);
        sctl.addr = {i_r, SLOT_W'(cnt_sel - CNT_W'(1))};
      end
      S_FILE: begin
        sctl.we   = file_ok;
        sctl.addr = {quo_r[CLS_W-1:0], SLOT_W'(cnt_sel)};
      end
      S_FCHK: begin
        sctl.we   = free_ok;
        sctl.addr = {quo_r[CLS_W-1:0], SLOT_W'(cnt_sel)};
        ram_wdata = foff_r;
      end
      default: sctl = '0;
    endcase
  end

  scba_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (sctl.we),
    .re    (sctl.re),
    .addr  (sctl.addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      block_r  <= BLK_W'(64);
      segblk_r <= BLK_W'(1024);
      pool_r   <= '0;
      head_r   <= '0;
      ovalid_r <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k]    <= '0;
        segoff_r[k] <= '0;
        segrem_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BLOCK_BYTES:    block_r  <= cfg_wdata[BLK_W-1:0];
          REG_SEGMENT_BLOCKS: segblk_r <= cfg_wdata[BLK_W-1:0];
          REG_POOL_BYTES:     pool_r   <= cfg_wdata[POOL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_SCAN: begin
          if (rem_short && cnt_sel != '0) cnt_r[i_r] <= cnt_sel - CNT_W'(1);
        end
        S_CLAIM: begin
          if (claim_open) head_r <= head_sum;
          if (claim_open && claim_fit) begin
            segoff_r[cls_r] <= head_r[OFFSET_BITS-1:0];
            segrem_r[cls_r] <= segb_r;
          end
        end
        S_FILE: if (file_ok) cnt_r[quo_r[CLS_W-1:0]] <= cnt_sel + CNT_W'(1);
        S_FCHK: if (free_ok) cnt_r[quo_r[CLS_W-1:0]] <= cnt_sel + CNT_W'(1);
        S_GRANT: begin
          segrem_r[i_r] <= segrem_sel - SEG_W'(aln_r);
          segoff_r[i_r] <= segoff_sel + OFFSET_BITS'(aln_r);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      ostatus_r <= res_status_r;
      ooff_r    <= res_off_r;
      ogrant_r  <= res_grant_r;
    end
    unique case (state_r)
      S_IDLE: begin
        size_r <= in_ch.size_bytes;
        foff_r <= in_ch.free_offset;
        res_off_r    <= '0;
        res_grant_r  <= '0;
        if (block_r == '0) begin
          res_status_r <= (in_ch.command == CMD_FREE) ? ST_FREE_REJ : ST_BAD_SIZE;
        end else begin
          res_status_r <= ST_OK;
        end
        quo_r   <= DVD_W'(in_ch.size_bytes);
        rem_r   <= '0;
        dcnt_r  <= DCNT_W'(DVD_W);
        dmode_r <= (in_ch.command == CMD_FREE) ? DIV_FREE : DIV_ALLOC;
      end
      S_MSEG: segb_r <= prod;
      S_DIV: begin
        if (!div_done) begin
          rem_r  <= tbit ? (trial - {1'b0, block_r}) : trial;
          quo_r  <= {quo_r[DVD_W-2:0], tbit};
          dcnt_r <= dcnt_r - DCNT_W'(1);
        end
      end
      S_CLS: begin
        if (alloc_bad) res_status_r <= ST_BAD_SIZE;
        cls_r <= quo_r[CLS_W-1:0] + CLS_W'(rem_nz);
        i_r   <= quo_r[CLS_W-1:0] + CLS_W'(rem_nz);
      end
      S_MALN: aln_r <= prod[ALN_W-1:0];
      S_CHK: if (SEG_W'(aln_r) > segb_r) res_status_r <= ST_BAD_SIZE;
      S_CLAIM: begin
        if (claim_open && claim_fit) begin
          i_r       <= cls_r;
          fileoff_r <= segoff_sel;
          quo_r     <= segrem_sel;
          rem_r     <= '0;
          dcnt_r    <= DCNT_W'(DVD_W);
          dmode_r   <= DIV_FILE;
        end else if (last_cls) begin
          res_status_r <= ST_NO_SPACE;
        end else begin
          i_r <= i_r + CLS_W'(1);
        end
      end
      S_MULG: begin
        res_off_r   <= ram_rdata;
        res_grant_r <= SIZE_W'(prod[ALN_W-1:0]);
      end
      S_FCHK: if (!free_ok) res_status_r <= ST_FREE_REJ;
      S_GRANT: begin
        res_off_r   <= segoff_sel;
        res_grant_r <= SIZE_W'(aln_r);
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.status        = ostatus_r;
  assign out_ch.offset        = ooff_r;
  assign out_ch.granted_bytes = ogrant_r;

endmodule

>>> src/scba_ram.sv
// scba_ram: generic single-port RAM, one write or read per cycle, registered read
// no dependencies

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for size_class_block_allocator_core, with a directed table,
// then randomized allocate/free traffic over several register settings
// depends on scba_pkg, scba_in_if, scba_out_if and the core
`timescale 1ns / 100ps

module tb_top;
  import scba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  scba_in_if  req_ch ();
  scba_out_if res_ch ();

  size_class_block_allocator_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  typedef struct {
    status_t                st;
    logic [OFFSET_BITS-1:0] off;
    logic [SIZE_W-1:0]      grant;
  } alloc_res_t;

  typedef struct {
    command_t               cmd;
    logic [SIZE_W-1:0]      size;
    logic [OFFSET_BITS-1:0] off;
    bit                     typed;
    status_t                st;
    logic [OFFSET_BITS-1:0] exp_off;
    logic [SIZE_W-1:0]      exp_grant;
  } stim_row_t;

  // allocator shadow state
  logic [16:0] blk_bytes;
  logic [16:0] seg_blks;
  logic [39:0] pool_sz;
  logic [OFFSET_BITS-1:0] fl_store [NUM_CLASSES][FREE_DEPTH];
  int unsigned fl_count [NUM_CLASSES];
  logic [63:0] cur_seg_off [NUM_CLASSES];
  logic [63:0] cur_seg_left [NUM_CLASSES];
  logic [63:0] bump_head;

  alloc_res_t expected_q[$];
  logic [OFFSET_BITS-1:0] held_off[$];
  logic [SIZE_W-1:0]      held_size[$];
  int  errors = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  function automatic bit push_free(logic [63:0] bytes, logic [63:0] off);
    logic [63:0] c;
    if (blk_bytes == 0 || bytes == 0 || bytes % blk_bytes != 0) return 1'b0;
    c = bytes / blk_bytes;
    if (c >= NUM_CLASSES || fl_count[c] >= FREE_DEPTH) return 1'b0;
    fl_store[c][fl_count[c]] = off[OFFSET_BITS-1:0];
    fl_count[c]++;
    return 1'b1;
  endfunction

  function automatic bit claim_seg(int c, logic [63:0] seg_bytes);
    logic [63:0] h;
    h = bump_head;
    if (h >= pool_sz) return 1'b0;
    bump_head = h + seg_bytes;
    if (h + seg_bytes > pool_sz) return 1'b0;
    if (cur_seg_left[c] > 0) void'(push_free(cur_seg_left[c], cur_seg_off[c]));
    cur_seg_off[c] = h & {{(64-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
    cur_seg_left[c] = seg_bytes;
    return 1'b1;
  endfunction

  function automatic alloc_res_t predict_alloc(command_t cmd, logic [31:0] size,
                                               logic [39:0] off);
    alloc_res_t r;
    logic [63:0] seg_bytes, c, aligned;
    int i;
    r.st = ST_OK; r.off = '0; r.grant = '0;
    if (cmd == CMD_FREE) begin
      if (!push_free(64'(size), 64'(off))) r.st = ST_FREE_REJ;
      return r;
    end
    if (blk_bytes == 0) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    seg_bytes = seg_blks * blk_bytes;
    c = (64'(size) + blk_bytes - 1) / blk_bytes;
    aligned = c * blk_bytes;
    if (aligned == 0 || aligned > seg_bytes || c >= NUM_CLASSES) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    i = int'(c);
    while (i < NUM_CLASSES) begin
      if (cur_seg_left[i] < aligned) begin
        if (fl_count[i] > 0) begin
          fl_count[i]--;
          r.off = fl_store[i][fl_count[i]];
          r.grant = 32'(i * blk_bytes);
          return r;
        end
        if (!claim_seg(int'(c), seg_bytes)) begin
          i++;
          continue;
        end
        i = int'(c);
      end
      r.off = cur_seg_off[i][OFFSET_BITS-1:0];
      r.grant = aligned[31:0];
      cur_seg_left[i] -= aligned;
      cur_seg_off[i] = (cur_seg_off[i] + aligned) &
                       {{(64-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
      return r;
    end
    r.st = ST_NO_SPACE;
    return r;
  endfunction

  // one request transfer; valid stays high into the next call unless it idles
  task automatic send_req(command_t cmd, logic [31:0] size, logic [39:0] off);
    alloc_res_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.size_bytes <= size;
    req_ch.free_offset <= off;
    do @(posedge clk); while (!req_ch.ready);
    r = predict_alloc(cmd, size, off);
    expected_q.push_back(r);
    if (cmd == CMD_ALLOC && r.st == ST_OK && held_off.size() < 400) begin
      held_off.push_back(r.off);
      held_size.push_back(r.grant);
    end
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_regs(logic [16:0] bb, logic [16:0] sb, logic [39:0] pb);
    cfg_we <= 1'b1; cfg_index <= REG_BLOCK_BYTES; cfg_wdata <= 40'(bb);
    @(negedge clk);
    cfg_index <= REG_SEGMENT_BLOCKS; cfg_wdata <= 40'(sb);
    @(negedge clk);
    cfg_index <= REG_POOL_BYTES; cfg_wdata <= pb;
    @(negedge clk);
    cfg_we <= 1'b0;
    blk_bytes = bb; seg_blks = sb; pool_sz = pb;
  endtask

  // result channel stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%h granted=%h", $time,
                 res_ch.status, res_ch.offset, res_ch.granted_bytes);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, res_ch.status);
          errors++;
        end
        if (res_ch.offset !== e.off) begin
          $display("%0t: offset exp %h got %h", $time, e.off, res_ch.offset);
          errors++;
        end
        if (res_ch.granted_bytes !== e.grant) begin
          $display("%0t: granted exp %h got %h", $time, e.grant, res_ch.granted_bytes);
          errors++;
        end
      end
    end
  end

  stim_row_t dir_rows[$];

  task automatic run_random(int n_items);
    logic [63:0] lim;
    logic [31:0] sz;
    int k, pick, j;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        lim = 64'(seg_blks) * blk_bytes;
        if (lim > 31 * 64'(blk_bytes)) lim = 31 * 64'(blk_bytes);
        if (lim == 0) sz = $urandom_range(0, 100);
        else sz = $urandom_range(1, 32'(lim));
        send_req(CMD_ALLOC, sz, 40'({$urandom, $urandom}));
      end else if (pick < 9 && held_off.size() > 0) begin
        j = $urandom_range(0, held_off.size() - 1);
        send_req(CMD_FREE, held_size[j], held_off[j]);
        held_off.delete(j);
        held_size.delete(j);
      end else begin
        send_req(command_t'($urandom_range(0, 1)), $urandom,
                 40'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    stim_row_t row;
    int k;
    blk_bytes = 17'd64; seg_blks = 17'd1024; pool_sz = '0;
    bump_head = '0;
    for (k = 0; k < NUM_CLASSES; k++) begin
      fl_count[k] = 0; cur_seg_off[k] = '0; cur_seg_left[k] = '0;
    end
    req_ch.valid = 1'b0; req_ch.command = CMD_ALLOC;
    req_ch.size_bytes = '0; req_ch.free_offset = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: empty pool, so only freed space can be granted
    dir_rows = '{
      '{CMD_ALLOC, 32'd0,         40'd0, 1, ST_BAD_SIZE, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd64,        40'd0, 1, ST_NO_SPACE, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'hFFFF_FFFF, 40'd0, 1, ST_BAD_SIZE, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd1985,      40'd0, 1, ST_BAD_SIZE, 40'd0, 32'd0},
      '{CMD_FREE,  32'd0,         40'd5, 1, ST_FREE_REJ, 40'd0, 32'd0},
      '{CMD_FREE,  32'd100,       40'd5, 1, ST_FREE_REJ, 40'd0, 32'd0},
      '{CMD_FREE,  32'd2048,      40'd5, 1, ST_FREE_REJ, 40'd0, 32'd0},
      '{CMD_FREE,  32'hFFFF_FFC0, 40'hFF_FFFF_FFFF, 1, ST_FREE_REJ, 40'd0, 32'd0},
      '{CMD_FREE,  32'd64,        40'hFF_FFFF_FFFF, 1, ST_OK, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd1,         40'd0, 1, ST_OK, 40'hFF_FFFF_FFFF, 32'd64},
      '{CMD_FREE,  32'd1984,      40'hAA_AAAA_AAAA, 1, ST_OK, 40'd0, 32'd0},
      '{CMD_FREE,  32'd192,       40'h55_5555_5555, 1, ST_OK, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd65,        40'd0, 0, ST_OK, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd1984,      40'd0, 0, ST_OK, 40'd0, 32'd0},
      '{CMD_ALLOC, 32'd1984,      40'd0, 0, ST_OK, 40'd0, 32'd0}
    };
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.typed) begin
        // typed rows carry their own result; still run the shadow to keep state
        send_req(row.cmd, row.size, row.off);
        expected_q[expected_q.size()-1] = '{row.st, row.exp_off, row.exp_grant};
      end else begin
        send_req(row.cmd, row.size, row.off);
      end
    end
    drain_and_settle();

    write_regs(17'd64, 17'd1024, 40'h40_0000);       run_random(350);  drain_and_settle();
    write_regs(17'd1, 17'd1, 40'd200);               run_random(200);  drain_and_settle();
    write_regs(17'd65536, 17'd65536, 40'hFF_FFFF_FFFF); run_random(300); drain_and_settle();
    write_regs(17'd3, 17'd65536, 40'd5000);          run_random(250);  drain_and_settle();
    write_regs(17'd0, 17'd16, 40'd1000);             run_random(50);   drain_and_settle();
    write_regs(17'd100, 17'd7, 40'hFF_FFFF_FFFF);    run_random(300);  drain_and_settle();
    write_regs(17'd64, 17'd1024, 40'h100_0000);
    quiet = 1'b1;
    run_random(450);
    req_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(negedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
